// ===== rtl/pcl_pkg.sv =====
package pcl_pkg;

   localparam int INDEX_BITS  = 6;
   localparam int CFG_BITS    = 7;
   localparam int WEIGHT_BITS = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic capture;
      logic rd_en;
      logic rd_first;
      logic rd_last;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ===== rtl/pcl_ctrl.sv =====
module pcl_ctrl
   import pcl_pkg::*;
#(
   parameter int MAX_SITES = 64,
   parameter int ADDR_W    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_wr_en,
   input  logic [CFG_BITS-1:0]   csr_wr_data,
   input  status_type            status,
   output cmd_type               cmd,
   output logic [ADDR_W-1:0]     rd_addr
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      FINISH
   } state_type;

   state_type             state_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [ADDR_W-1:0]     last_ff;
   logic [ADDR_W-1:0]     last_in;
   logic                  rsp_valid_ff;
   logic [CFG_BITS-1:0]   sites_ff;
   logic [31:0]           n_wide;
   logic [31:0]           last_wide;
   logic                  accept;
   logic                  out_free;

   assign accept   = req_valid && (state_ff == IDLE) && !reset;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // clamp the site count into one .. MAX_SITES
   always_comb begin
      n_wide = 32'(sites_ff);
      if (n_wide == 32'd0) begin
         n_wide = 32'd1;
      end
      if (n_wide > 32'(MAX_SITES)) begin
         n_wide = 32'(MAX_SITES);
      end
      last_wide = n_wide - 32'd1;
      last_in   = last_wide[ADDR_W-1:0];
   end

   always_comb begin
      cmd          = '0;
      cmd.wr_en    = accept && (req_opcode == OP_LOAD);
      cmd.capture  = accept && (req_opcode == OP_QUERY);
      cmd.rd_en    = (state_ff == SCAN);
      cmd.rd_first = (state_ff == SCAN) && (addr_ff == '0);
      cmd.rd_last  = (state_ff == SCAN) && (addr_ff == last_ff);
      cmd.rsp_load = (state_ff == FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         addr_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sites_ff     <= CFG_BITS'(1);
      end else begin
         if (csr_wr_en) begin
            sites_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept && (req_opcode == OP_QUERY)) begin
                  addr_ff  <= '0;
                  last_ff  <= last_in;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (addr_ff == last_ff) begin
                  state_ff <= DRAIN;
               end else begin
                  addr_ff <= addr_ff + ADDR_W'(1);
               end
            end
            DRAIN: begin
               if (status.scan_done) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = addr_ff;

endmodule

// ===== rtl/pcl_datapath.sv =====
module pcl_datapath
   import pcl_pkg::*;
#(
   parameter int MAX_SITES  = 64,
   parameter int COORD_BITS = 16,
   parameter int ADDR_W     = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic [ADDR_W-1:0]            rd_addr,
   input  logic [INDEX_BITS-1:0]        req_site_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic [WEIGHT_BITS-1:0]       req_weight_sq,
   output status_type                   status,
   output logic [INDEX_BITS-1:0]        rsp_cell_index
);

   localparam int CB    = COORD_BITS;
   localparam int ENT_W = 2 * CB + WEIGHT_BITS;
   localparam int SQ_W  = 2 * CB;
   localparam int D_W   = SQ_W + 1;
   localparam int S_W   = ((D_W > WEIGHT_BITS) ? D_W : WEIGHT_BITS) + 1;

   logic [ENT_W-1:0]        mem [MAX_SITES];
   logic [31:0]             wr_wide;
   logic                    wr_ok;

   logic signed [CB-1:0]    qx_ff, qy_ff;

   logic                    v1_ff, first1_ff, last1_ff;
   logic [ADDR_W-1:0]       idx1_ff;
   logic [ENT_W-1:0]        ent1_ff;

   logic                    v2_ff, first2_ff, last2_ff;
   logic [ADDR_W-1:0]       idx2_ff;
   logic [CB-1:0]           adx2_ff, ady2_ff;
   logic [WEIGHT_BITS-1:0]  w2_ff;

   logic                    v3_ff, first3_ff, last3_ff;
   logic [ADDR_W-1:0]       idx3_ff;
   logic [SQ_W-1:0]         sqx3_ff, sqy3_ff;
   logic [WEIGHT_BITS-1:0]  w3_ff;

   logic                    v4_ff, first4_ff, last4_ff;
   logic [ADDR_W-1:0]       idx4_ff;
   logic [D_W-1:0]          d4_ff;
   logic [WEIGHT_BITS-1:0]  w4_ff;

   logic [D_W-1:0]          best_d_ff;
   logic [WEIGHT_BITS-1:0]  best_w_ff;
   logic [ADDR_W-1:0]       best_idx_ff;
   logic [INDEX_BITS-1:0]   rsp_cell_ff;

   logic signed [CB:0]      dx, dy;
   logic [CB-1:0]           adx, ady;
   logic signed [CB-1:0]    ex, ey;
   logic [S_W-1:0]          lhs, rhs;
   logic                    take;
   logic [31:0]             best_wide;

   assign wr_wide = 32'(req_site_index);
   assign wr_ok   = wr_wide < 32'(MAX_SITES);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[wr_wide[ADDR_W-1:0]] <= {req_coord_x, req_coord_y, req_weight_sq};
      end
      if (cmd.rd_en) begin
         ent1_ff <= mem[rd_addr];
      end
   end

   // absolute coordinate differences
   always_comb begin
      ex  = ent1_ff[ENT_W-1 -: CB];
      ey  = ent1_ff[ENT_W-CB-1 -: CB];
      dx  = {qx_ff[CB-1], qx_ff} - {ex[CB-1], ex};
      dy  = {qy_ff[CB-1], qy_ff} - {ey[CB-1], ey};
      adx = dx[CB] ? CB'(-dx) : CB'(dx);
      ady = dy[CB] ? CB'(-dy) : CB'(dy);
   end

   // d + w_best < d_best + w compares power distances without going negative
   always_comb begin
      lhs  = S_W'(d4_ff) + S_W'(best_w_ff);
      rhs  = S_W'(best_d_ff) + S_W'(w4_ff);
      take = v4_ff && (first4_ff || (lhs < rhs));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
      end
      first1_ff <= cmd.rd_first;
      last1_ff  <= cmd.rd_last;
      idx1_ff   <= rd_addr;

      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      idx2_ff   <= idx1_ff;
      adx2_ff   <= adx;
      ady2_ff   <= ady;
      w2_ff     <= ent1_ff[WEIGHT_BITS-1:0];

      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      idx3_ff   <= idx2_ff;
      sqx3_ff   <= SQ_W'(adx2_ff) * SQ_W'(adx2_ff);
      sqy3_ff   <= SQ_W'(ady2_ff) * SQ_W'(ady2_ff);
      w3_ff     <= w2_ff;

      first4_ff <= first3_ff;
      last4_ff  <= last3_ff;
      idx4_ff   <= idx3_ff;
      d4_ff     <= D_W'(sqx3_ff) + D_W'(sqy3_ff);
      w4_ff     <= w3_ff;

      if (take) begin
         best_d_ff   <= d4_ff;
         best_w_ff   <= w4_ff;
         best_idx_ff <= idx4_ff;
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= best_wide[INDEX_BITS-1:0];
      end
   end

   assign best_wide        = 32'(best_idx_ff);
   assign status.scan_done = v4_ff && last4_ff;
   assign rsp_cell_index   = rsp_cell_ff;

endmodule

// ===== rtl/power_cell_locator.sv =====
// load transaction: no response; one load per cycle while no query is in progress
// query transaction: one response once all n stored sites are scanned, n being sites_in_use
//   clamped to one .. MAX_SITES; one stored site per cycle goes through the distance pipeline
// next transaction is taken after a query once the result is registered
// reset (synchronous, active high) clears control and sets sites_in_use to one;
//   the site table is not cleared
module power_cell_locator
   import pcl_pkg::*;
#(
   parameter int MAX_SITES  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [INDEX_BITS-1:0]        req_site_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic [WEIGHT_BITS-1:0]       req_weight_sq,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [INDEX_BITS-1:0]        rsp_cell_index,
   input  logic                         csr_wr_en,
   input  logic [CFG_BITS-1:0]          csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_SITES);

   cmd_type            cmd;
   status_type         status;
   logic [ADDR_W-1:0]  rd_addr;

   pcl_ctrl #(
      .MAX_SITES (MAX_SITES),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   pcl_datapath #(
      .MAX_SITES  (MAX_SITES),
      .COORD_BITS (COORD_BITS),
      .ADDR_W     (ADDR_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .req_site_index (req_site_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_weight_sq  (req_weight_sq),
      .status         (status),
      .rsp_cell_index (rsp_cell_index)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import pcl_pkg::*;

   localparam int SITE_COUNT     = 64;
   localparam int COORD_BITS     = 16;
   localparam int SCAN_SETTLE    = SITE_COUNT + 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 100;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                   opcode;
      logic [INDEX_BITS-1:0]  site_index;
      coord_type              coord_x;
      coord_type              coord_y;
      logic [WEIGHT_BITS-1:0] weight_sq;
   } site_req_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_opcode     = OP_LOAD;
   logic [INDEX_BITS-1:0]  req_site_index = '0;
   coord_type              req_coord_x    = '0;
   coord_type              req_coord_y    = '0;
   logic [WEIGHT_BITS-1:0] req_weight_sq  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [INDEX_BITS-1:0]  rsp_cell_index;
   logic                   csr_wr_en      = 1'b0;
   logic [CFG_BITS-1:0]    csr_wr_data    = '0;

   coord_type              site_x [SITE_COUNT] = '{default: '0};
   coord_type              site_y [SITE_COUNT] = '{default: '0};
   logic [WEIGHT_BITS-1:0] site_w [SITE_COUNT] = '{default: '0};
   logic [CFG_BITS-1:0]    sites_in_use = 7'd1;
   logic [INDEX_BITS-1:0]  expected_cells [$];

   int error_count     = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;
   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;

   power_cell_locator #(
      .MAX_SITES  (SITE_COUNT),
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_site_index (req_site_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_weight_sq  (req_weight_sq),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_index (rsp_cell_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int scan_length();
      if (sites_in_use == 0) return 1;
      if (sites_in_use > SITE_COUNT) return SITE_COUNT;
      return int'(sites_in_use);
   endfunction

   function automatic longint power_distance(coord_type px, coord_type py, int i);
      longint dx, dy;
      dx = longint'(px) - longint'(site_x[i]);
      dy = longint'(py) - longint'(site_y[i]);
      return dx * dx + dy * dy - longint'(site_w[i]);
   endfunction

   // lowest index wins on equal power distance
   function automatic logic [INDEX_BITS-1:0] locate_cell(coord_type px, coord_type py);
      int best;
      longint best_pow, pow;
      best = 0;
      best_pow = power_distance(px, py, 0);
      for (int i = 1; i < scan_length(); i++) begin
         pow = power_distance(px, py, i);
         if (pow < best_pow) begin
            best = i;
            best_pow = pow;
         end
      end
      return best[INDEX_BITS-1:0];
   endfunction

   function automatic void record_item(site_req_type it);
      if (it.opcode == OP_LOAD) begin
         site_x[it.site_index] = it.coord_x;
         site_y[it.site_index] = it.coord_y;
         site_w[it.site_index] = it.weight_sq;
      end else begin
         expected_cells = {expected_cells, locate_cell(it.coord_x, it.coord_y)};
      end
   endfunction

   function automatic site_req_type make_item(logic op, int idx, coord_type x, coord_type y,
                                              logic [WEIGHT_BITS-1:0] w);
      site_req_type it;
      it.opcode = op;
      it.site_index = idx[INDEX_BITS-1:0];
      it.coord_x = x;
      it.coord_y = y;
      it.weight_sq = w;
      return it;
   endfunction

   function automatic coord_type random_coord(int kind);
      case (kind)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 128)) - 64);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] random_weight(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 4096);
         default: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   // random, clustered, corner or a copy of another entry (for ties)
   function automatic site_req_type random_load(int idx);
      int kind, src;
      kind = $urandom_range(0, 3);
      if (kind == 3) begin
         src = $urandom_range(0, SITE_COUNT - 1);
         return make_item(OP_LOAD, idx, site_x[src], site_y[src], site_w[src]);
      end
      return make_item(OP_LOAD, idx, random_coord(kind), random_coord(kind),
                       random_weight(kind));
   endfunction

   function automatic site_req_type random_query();
      int kind, src;
      coord_type px, py;
      kind = $urandom_range(0, 3);
      if (kind == 3) begin
         src = $urandom_range(0, scan_length() - 1);
         px = site_x[src];
         py = site_y[src];
      end else begin
         px = random_coord(kind);
         py = random_coord(kind);
      end
      return make_item(OP_QUERY, $urandom_range(0, SITE_COUNT - 1), px, py, $urandom);
   endfunction

   function automatic site_req_type random_item();
      int idx;
      if ($urandom_range(0, 99) < 35) begin
         idx = ($urandom_range(0, 99) < 70) ? $urandom_range(0, scan_length() - 1)
                                             : $urandom_range(0, SITE_COUNT - 1);
         return random_load(idx);
      end
      return random_query();
   endfunction

   function automatic int next_gap();
      int roll;
      if (!sender_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_item(input site_req_type it);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= it.opcode;
      req_site_index <= it.site_index;
      req_coord_x    <= it.coord_x;
      req_coord_y    <= it.coord_y;
      req_weight_sq  <= it.weight_sq;
      do @(posedge clock); while (!req_ready);
      record_item(it);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   task automatic set_sites_in_use(input logic [CFG_BITS-1:0] value);
      drain_results();
      repeat (SCAN_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sites_in_use = value;
   endtask

   task automatic run_random_items(input int count);
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) drain_results();
         send_item(random_item());
      end
   endtask

   task automatic test_single_site();
      send_item(make_item(OP_LOAD, 0, -32768, 32767, 32'hFFFF_FFFF));
      send_item(make_item(OP_QUERY, 0, 32767, -32768, 32'h0));
      send_item(make_item(OP_QUERY, 63, 0, 0, 32'hFFFF_FFFF));
   endtask

   task automatic test_ties_and_weights();
      set_sites_in_use(7'd4);
      send_item(make_item(OP_LOAD, 0, 0, 0, 32'h0));
      send_item(make_item(OP_LOAD, 1, 0, 0, 32'h0));
      send_item(make_item(OP_LOAD, 2, 100, 0, 32'h0));
      send_item(make_item(OP_LOAD, 3, 32767, 32767, 32'hFFFF_FFFF));
      send_item(make_item(OP_QUERY, 0, 0, 0, 32'h0));
      send_item(make_item(OP_QUERY, 0, 50, 0, 32'h0));
      send_item(make_item(OP_QUERY, 0, 51, 0, 32'h0));
      send_item(make_item(OP_QUERY, 0, -32768, -32768, 32'h0));
      send_item(make_item(OP_LOAD, 1, 0, 0, 32'h1));
      send_item(make_item(OP_QUERY, 0, 0, 0, 32'h0));
      send_item(make_item(OP_LOAD, 3, -32768, -32768, 32'hFFFF_FFFF));
      send_item(make_item(OP_QUERY, 0, -32768, -32768, 32'h0));
   endtask

   task automatic test_table_fill();
      for (int i = 0; i < SITE_COUNT; i++) send_item(random_load(i));
   endtask

   task automatic test_register_range();
      logic [CFG_BITS-1:0] settings [8] = '{7'd64, 7'd0, 7'd1, 7'd127,
                                            7'd2, 7'd65, 7'd33, 7'd63};
      for (int p = 0; p < 8; p++) begin
         set_sites_in_use(settings[p]);
         sender_gaps     = (p % 3 != 1);
         receiver_stalls = (p % 3 != 2);
         run_random_items(PHASE_ITEMS);
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic test_back_to_back();
      set_sites_in_use(7'($urandom_range(1, 127)));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      run_random_items(80);
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // response checking and ready throttling
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %0d",
                     $time, rsp_cell_index);
            error_count++;
         end else begin
            if (rsp_cell_index !== expected_cells[0]) begin
               $display("%0t: cell_index mismatch, expected %0d, actual %0d",
                        $time, expected_cells[0], rsp_cell_index);
               error_count++;
            end
            void'(expected_cells.pop_front());
         end
      end
      if (!receiver_stalls) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 4) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: watchdog expired", $time);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_site();
      test_ties_and_weights();
      test_table_fill();
      test_register_range();
      test_back_to_back();
      drain_results();
      repeat (SCAN_SETTLE) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
